// ===== rtl/core/ssb_envelope_phase_modulator_macros.svh =====
// assertion macros for the ssb envelope and phase modulator
// used by rtl/core/ssb_envelope_phase_modulator.sv, no other dependencies
`ifndef SSB_ENVELOPE_PHASE_MODULATOR_MACROS_SVH
`define SSB_ENVELOPE_PHASE_MODULATOR_MACROS_SVH
`ifndef SYNTHESIS
`define SEPM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sepm assertion failed");
`define SEPM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sepm assertion failed");
`else
`define SEPM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SEPM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/sepm_pkg.sv =====
// package for the ssb envelope and phase modulator: widths, constants,
// register indexes, sequencer states and the cordic angle table; no dependencies
`default_nettype none
package sepm_pkg;
	localparam int SAMPLE_W     = 24;
	localparam int PERIOD_W     = 16;
	localparam int COEF_W       = 16;
	localparam int CODE_W       = 6;
	localparam int TAP_COUNT    = 7;
	localparam int CORDIC_STEPS = 16;
	localparam int ROT_CNT_W    = 5;
	localparam int CW           = 34;
	localparam int ACC_W        = 44;
	localparam int PROD_W       = 42;
	localparam int MAG_W        = 33;
	localparam int SUM_W        = 37;
	localparam int NUM_W        = SUM_W + PERIOD_W;
	localparam int REM_W        = 32;
	localparam int DIV_CNT_W    = 6;
	localparam int PH_W         = 41;

	localparam logic [SUM_W-1:0] FULL_SCALE = 37'd8388607;
	localparam logic [SUM_W-1:0] QUAD_UNIT  = 37'd134217712;
	localparam logic [30:0] ENV_DIV  = 31'd83886070;
	localparam logic [30:0] QUAD_DIV = 31'd1342177120;
	localparam logic [29:0] KINV_Q30 = 30'd652032874;
	localparam logic signed [CW-1:0] Z_PI = 34'sd2147483648;
	localparam logic [CODE_W-1:0] CODE_MAX = 6'd63;

	typedef enum logic [2:0] {
		REG_ENABLE, REG_METHOD, REG_PERIOD, REG_OUTER, REG_INNER, REG_MID
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MAC, ST_INIT, ST_ROT, ST_MAG, ST_SUM, ST_NUM, ST_DIV, ST_LOAD
	} state_t;

	// atan(2^-i) with pi = 2^31
	function automatic logic [29:0] atan_of(input logic [ROT_CNT_W-1:0] i);
		logic [29:0] r;
		case (i)
			5'd0: r = 30'd536870912;
			5'd1: r = 30'd316933406;
			5'd2: r = 30'd167458907;
			5'd3: r = 30'd85004756;
			5'd4: r = 30'd42667331;
			5'd5: r = 30'd21354465;
			5'd6: r = 30'd10679838;
			5'd7: r = 30'd5340245;
			5'd8: r = 30'd2670163;
			5'd9: r = 30'd1335087;
			5'd10: r = 30'd667544;
			5'd11: r = 30'd333772;
			5'd12: r = 30'd166886;
			5'd13: r = 30'd83443;
			5'd14: r = 30'd41722;
			5'd15: r = 30'd20861;
			5'd16: r = 30'd10430;
			5'd17: r = 30'd5215;
			5'd18: r = 30'd2608;
			5'd19: r = 30'd1304;
			5'd20: r = 30'd652;
			5'd21: r = 30'd326;
			5'd22: r = 30'd163;
			5'd23: r = 30'd81;
			default: r = 30'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/ssb_envelope_phase_modulator.sv =====
// Each accepted sample while enabled gives one request with a pwm level,
// and in quadrature mode a phase code. One sample is in work at a time:
// quadrature mode runs 3 filter multiply steps, an init state, 16 cordic
// steps and the magnitude and sum states; both modes are dominated by
// the bit-serial divider that produces 53 quotient bits, one per cycle.
// A disabled sample is taken without leaving idle and gives nothing. A finished
// result waits in the output register while the next sample is taken.
// Writing enable clears the 7-tap delay line at once.
// depends on sepm_pkg and ssb_envelope_phase_modulator_macros.svh
`default_nettype none
`include "ssb_envelope_phase_modulator_macros.svh"
module ssb_envelope_phase_modulator
	import sepm_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [2:0]                 cfg_index,
	input  wire logic [15:0]                cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [PERIOD_W-1:0]             pwm_level,
	output logic [CODE_W-1:0]               phase_code,
	output logic                            phase_valid
);
	logic enable_q, method_q;
	logic [PERIOD_W-1:0] period_q;
	logic [COEF_W-1:0] coef_outer_q, coef_inner_q, coef_mid_q;
	logic signed [SAMPLE_W-1:0] hist_q [TAP_COUNT];

	state_t state_q, state_d;
	logic mode_q;
	logic [1:0] mac_cnt_q;
	logic [ROT_CNT_W-1:0] rot_cnt_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [CW-1:0] cx_q, cy_q, z_q;
	logic [62:0] mag_prod_q;
	logic signed [PH_W-1:0] ph_prod_q;
	logic [SUM_W-1:0] sum_q;
	logic [NUM_W-1:0] num_q;
	logic [REM_W-1:0] rem_q;
	logic [CODE_W-1:0] code_q;
	logic out_valid_q, phase_valid_q;
	logic [PERIOD_W-1:0] pwm_level_q;
	logic [CODE_W-1:0] phase_code_q;

	logic in_fire, load_out, hist_clear;
	logic signed [SAMPLE_W:0] mac_diff;
	logic [COEF_W-1:0] mac_coef;
	logic signed [PROD_W-1:0] mac_prod;
	logic signed [CW-1:0] x0, y0, sh_x, sh_y, atan_step;
	logic [SAMPLE_W-1:0] abs_x;
	logic [MAG_W-1:0] cx_pos;
	logic [9:0] code_raw;
	logic [REM_W-1:0] trial, div_ext;
	logic div_ge;
	logic [PERIOD_W-1:0] level;

	assign in_fire    = in_valid && in_ready;
	assign hist_clear = cfg_we && (cfg_index == REG_ENABLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire && enable_q) state_d = method_q ? ST_MAC : ST_NUM;
			ST_MAC:  if (mac_cnt_q == 2'd2) state_d = ST_INIT;
			ST_INIT: state_d = ST_ROT;
			ST_ROT:  if (rot_cnt_q == ROT_CNT_W'(CORDIC_STEPS - 1)) state_d = ST_MAG;
			ST_MAG:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_NUM;
			ST_NUM:  state_d = ST_DIV;
			ST_DIV:  if (div_cnt_q == DIV_CNT_W'(NUM_W - 1)) state_d = ST_LOAD;
			ST_LOAD: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_LOAD: load_out = !out_valid_q || out_ready;
			default: begin
				in_ready = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	// datapath helpers
	always_comb begin
		case (mac_cnt_q)
			2'd0: begin
				mac_diff = {hist_q[0][SAMPLE_W-1], hist_q[0]} - {hist_q[6][SAMPLE_W-1], hist_q[6]};
				mac_coef = coef_outer_q;
			end
			2'd1: begin
				mac_diff = {hist_q[2][SAMPLE_W-1], hist_q[2]} - {hist_q[4][SAMPLE_W-1], hist_q[4]};
				mac_coef = coef_inner_q;
			end
			default: begin
				mac_diff = {hist_q[1][SAMPLE_W-1], hist_q[1]} - {hist_q[5][SAMPLE_W-1], hist_q[5]};
				mac_coef = coef_mid_q;
			end
		endcase
	end
	assign mac_prod  = mac_diff * $signed({1'b0, mac_coef});
	assign x0        = {{6{hist_q[3][SAMPLE_W-1]}}, hist_q[3], 4'b0000};
	assign y0        = {{2{acc_q[ACC_W-1]}}, acc_q[ACC_W-1:12]};
	assign sh_x      = cx_q >>> rot_cnt_q;
	assign sh_y      = cy_q >>> rot_cnt_q;
	assign atan_step = $signed({4'b0000, atan_of(rot_cnt_q)});
	assign abs_x     = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
	assign cx_pos    = cx_q[CW-1] ? '0 : cx_q[MAG_W-1:0];
	assign code_raw  = ph_prod_q[PH_W-1:31];
	assign div_ext   = {1'b0, mode_q ? QUAD_DIV : ENV_DIV};
	assign trial     = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
	assign div_ge    = trial >= div_ext;
	assign level     = ((|num_q[NUM_W-1:PERIOD_W]) || (num_q[PERIOD_W-1:0] > period_q))
		? period_q : num_q[PERIOD_W-1:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			method_q     <= 1'b0;
			period_q     <= 16'd1333;
			coef_outer_q <= 16'd39505;
			coef_inner_q <= 16'd16122;
			coef_mid_q   <= 16'd5453;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE: enable_q     <= cfg_data[0];
				REG_METHOD: method_q     <= cfg_data[0];
				REG_PERIOD: period_q     <= cfg_data;
				REG_OUTER:  coef_outer_q <= cfg_data;
				REG_INNER:  coef_inner_q <= cfg_data;
				REG_MID:    coef_mid_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// delay line, newest at tap 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAP_COUNT; k++) hist_q[k] <= '0;
		end else if (hist_clear) begin
			for (int k = 0; k < TAP_COUNT; k++) hist_q[k] <= '0;
		end else if (in_fire && enable_q && method_q) begin
			hist_q[0] <= sample;
			for (int k = 1; k < TAP_COUNT; k++) hist_q[k] <= hist_q[k-1];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mac_cnt_q   <= '0;
			rot_cnt_q   <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mac_cnt_q <= (state_q == ST_MAC) ? mac_cnt_q + 2'd1 : 2'd0;
			rot_cnt_q <= (state_q == ST_ROT) ? rot_cnt_q + 1'b1 : '0;
			div_cnt_q <= (state_q == ST_DIV) ? div_cnt_q + 1'b1 : '0;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					mode_q <= method_q;
					sum_q  <= {10'b0, abs_x, 3'b000} + FULL_SCALE;
					code_q <= '0;
				end
			end
			ST_MAC: begin
				if (mac_cnt_q == 2'd0) acc_q <= {{2{mac_prod[PROD_W-1]}}, mac_prod};
				else acc_q <= acc_q + {{2{mac_prod[PROD_W-1]}}, mac_prod};
			end
			ST_INIT: begin
				// left half plane: turn by pi first
				if (x0[CW-1]) begin
					z_q  <= y0[CW-1] ? -Z_PI : Z_PI;
					cx_q <= -x0;
					cy_q <= -y0;
				end else begin
					z_q  <= '0;
					cx_q <= x0;
					cy_q <= y0;
				end
			end
			ST_ROT: begin
				if (!cy_q[CW-1]) begin
					cx_q <= cx_q + sh_y;
					cy_q <= cy_q - sh_x;
					z_q  <= z_q + atan_step;
				end else begin
					cx_q <= cx_q - sh_y;
					cy_q <= cy_q + sh_x;
					z_q  <= z_q - atan_step;
				end
			end
			ST_MAG: begin
				mag_prod_q <= {30'b0, cx_pos} * {33'b0, KINV_Q30};
				ph_prod_q  <= (z_q > 0) ? z_q * $signed(7'sd63) : '0;
			end
			ST_SUM: begin
				sum_q  <= {1'b0, mag_prod_q[62:30], 3'b000} + QUAD_UNIT;
				code_q <= (code_raw > 10'd63) ? CODE_MAX : code_raw[CODE_W-1:0];
			end
			ST_NUM: begin
				num_q <= {16'b0, sum_q} * {37'b0, period_q};
				rem_q <= '0;
			end
			ST_DIV: begin
				// restoring division, quotient shifts in as the dividend shifts out
				rem_q <= div_ge ? trial - div_ext : trial;
				num_q <= {num_q[NUM_W-2:0], div_ge};
			end
			default: ;
		endcase
		if (load_out) begin
			pwm_level_q   <= level;
			phase_code_q  <= code_q;
			phase_valid_q <= mode_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign pwm_level   = pwm_level_q;
	assign phase_code  = phase_code_q;
	assign phase_valid = phase_valid_q;

	`SEPM_ASSERT_NXT(a_busy_after_take, clk, arst_n, in_fire && enable_q, !in_ready)
	`SEPM_ASSERT_IMP(a_cordic_x_pos, clk, arst_n, state_q == ST_ROT, !cx_q[CW-1])
	`SEPM_ASSERT_IMP(a_div_count, clk, arst_n, state_q == ST_DIV, div_cnt_q < DIV_CNT_W'(NUM_W))
endmodule
`default_nettype wire
